/* rtl/core/e0_pkg.sv */
// ----------------------------------------------------------------------------
// e0_pkg
// Shared widths, reset seeds, register indexes and types for the E0
// keystream generator.
// ----------------------------------------------------------------------------
`default_nettype none

package e0_pkg;

    // Register widths.
    localparam int unsigned LfsrAW  = 25;
    localparam int unsigned LfsrBW  = 31;
    localparam int unsigned LfsrCW  = 33;
    localparam int unsigned LfsrDW  = 39;
    localparam int unsigned CarryW  = 2;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = LfsrDW;

    // Seed values after reset.
    localparam logic [LfsrAW-1:0] LfsrASeedRst  = 25'h0FF_FFFF;
    localparam logic [LfsrBW-1:0] LfsrBSeedRst  = 31'h3FFF_FFFF;
    localparam logic [LfsrCW-1:0] LfsrCSeedRst  = 33'h0_FFFF_FFFF;
    localparam logic [LfsrDW-1:0] LfsrDSeedRst  = 39'h2A_AAAA_AAAA;
    localparam logic [CarryW-1:0] CarrySeedRst  = 2'd1;
    localparam logic [CarryW-1:0] OldCarrySeedRst = 2'd0;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegLfsrASeed    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegLfsrBSeed    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegLfsrCSeed    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegLfsrDSeed    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegCarrySeed    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegOldCarrySeed = 3'd5;

    // Complete set of seeds handed from the register file to the core.
    typedef struct packed {
        logic [LfsrAW-1:0] lfsr_a;
        logic [LfsrBW-1:0] lfsr_b;
        logic [LfsrCW-1:0] lfsr_c;
        logic [LfsrDW-1:0] lfsr_d;
        logic [CarryW-1:0] carry_now;
        logic [CarryW-1:0] carry_old;
    } e0_seeds_t;

    // Feedback taps of the four registers.
    function automatic logic fb_a(input logic [LfsrAW-1:0] p);
        return p[7] ^ p[11] ^ p[19] ^ p[24];
    endfunction

    function automatic logic fb_b(input logic [LfsrBW-1:0] p);
        return p[11] ^ p[16] ^ p[23] ^ p[30];
    endfunction

    function automatic logic fb_c(input logic [LfsrCW-1:0] p);
        return p[3] ^ p[23] ^ p[27] ^ p[32];
    endfunction

    function automatic logic fb_d(input logic [LfsrDW-1:0] p);
        return p[3] ^ p[27] ^ p[35] ^ p[38];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/e0_cfg_regs.sv */
// ----------------------------------------------------------------------------
// e0_cfg_regs
// Seed register file, written through the plain configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module e0_cfg_regs
    import e0_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata,
    output e0_seeds_t                seeds
);

    e0_seeds_t seeds_reg;
    e0_seeds_t seeds_next;

    // Decode the write; indexes beyond the list leave everything unchanged.
    always_comb
    begin
        seeds_next = seeds_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                RegLfsrASeed:    seeds_next.lfsr_a    = cfg_wdata[LfsrAW-1:0];
                RegLfsrBSeed:    seeds_next.lfsr_b    = cfg_wdata[LfsrBW-1:0];
                RegLfsrCSeed:    seeds_next.lfsr_c    = cfg_wdata[LfsrCW-1:0];
                RegLfsrDSeed:    seeds_next.lfsr_d    = cfg_wdata[LfsrDW-1:0];
                RegCarrySeed:    seeds_next.carry_now = cfg_wdata[CarryW-1:0];
                RegOldCarrySeed: seeds_next.carry_old = cfg_wdata[CarryW-1:0];
                default:         seeds_next = seeds_reg;
            endcase
        end
    end

    // Seed storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeds_reg.lfsr_a    <= LfsrASeedRst;
            seeds_reg.lfsr_b    <= LfsrBSeedRst;
            seeds_reg.lfsr_c    <= LfsrCSeedRst;
            seeds_reg.lfsr_d    <= LfsrDSeedRst;
            seeds_reg.carry_now <= CarrySeedRst;
            seeds_reg.carry_old <= OldCarrySeedRst;
        end
        else
        begin
            seeds_reg <= seeds_next;
        end
    end

    assign seeds = seeds_reg;

endmodule

`default_nettype wire

/* rtl/core/e0_core.sv */
// ----------------------------------------------------------------------------
// e0_core
// Four LFSRs and the two-carry summation combiner; advances one step per
// accepted beat and returns that step's keystream bit.
// ----------------------------------------------------------------------------
`default_nettype none

module e0_core
    import e0_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire e0_seeds_t seeds,
    input  wire logic      step,
    input  wire logic      restart,
    output logic           key_bit
);

    e0_seeds_t state_reg;
    e0_seeds_t state_next;
    e0_seeds_t cur;
    logic      xa;
    logic      xb;
    logic      xc;
    logic      xd;
    logic [2:0]        sum;
    logic [CarryW-1:0] half;
    logic [CarryW-1:0] mixed;

    // Working state: a restart reloads from the seeds before the step.
    assign cur = restart ? seeds : state_reg;

    assign xa = cur.lfsr_a[0];
    assign xb = cur.lfsr_b[0];
    assign xc = cur.lfsr_c[0];
    assign xd = cur.lfsr_d[0];

    // Keystream bit and combiner carry update.
    always_comb
    begin
        key_bit = xa ^ xb ^ xc ^ xd ^ cur.carry_now[0];
        sum = {2'b00, xa} + {2'b00, xb} + {2'b00, xc} + {2'b00, xd}
            + {1'b0, cur.carry_now};
        half = sum[2:1];
        mixed = {cur.carry_old[1] ^ cur.carry_old[0], cur.carry_old[0]};

        state_next.carry_now = half ^ cur.carry_now ^ mixed;
        state_next.carry_old = cur.carry_now;
        state_next.lfsr_a = {cur.lfsr_a[LfsrAW-2:0], fb_a(cur.lfsr_a)};
        state_next.lfsr_b = {cur.lfsr_b[LfsrBW-2:0], fb_b(cur.lfsr_b)};
        state_next.lfsr_c = {cur.lfsr_c[LfsrCW-2:0], fb_c(cur.lfsr_c)};
        state_next.lfsr_d = {cur.lfsr_d[LfsrDW-2:0], fb_d(cur.lfsr_d)};
    end

    // Running state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.lfsr_a    <= LfsrASeedRst;
            state_reg.lfsr_b    <= LfsrBSeedRst;
            state_reg.lfsr_c    <= LfsrCSeedRst;
            state_reg.lfsr_d    <= LfsrDSeedRst;
            state_reg.carry_now <= CarrySeedRst;
            state_reg.carry_old <= OldCarrySeedRst;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/e0_keystream_generator.sv */
// ----------------------------------------------------------------------------
// e0_keystream_generator
// E0-style keystream generator: one keystream bit per input beat, also
// XORed onto the data bit.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    data_in, restart
//   output    out_valid / out_ready  key_bit, data_out
//   config    cfg_we                 cfg_index, cfg_wdata
//
// An input beat is processed in the cycle it is accepted and its result
// sits in the output register from the next cycle on: one beat per clock
// when not stalled; the only stall is a full output register not being taken.
// Reset loads the LFSRs and carries with the reset seeds; seed writes take
// effect at the next beat that has restart set.
// ----------------------------------------------------------------------------
`default_nettype none

module e0_keystream_generator
    import e0_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                data_in,
    input  wire logic                restart,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     key_bit,
    output logic                     data_out,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata
);

    e0_seeds_t seeds;
    logic      step;
    logic      z;
    logic      out_valid_reg;
    logic      key_bit_reg;
    logic      data_out_reg;

    e0_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .seeds     (seeds)
    );

    // Accept whenever the output register is empty or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    e0_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .seeds   (seeds),
        .step    (step),
        .restart (restart),
        .key_bit (z)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            key_bit_reg  <= z;
            data_out_reg <= data_in ^ z;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_bit   = key_bit_reg;
    assign data_out  = data_out_reg;

endmodule

`default_nettype wire
